// File: rtl/ps2md_pkg.sv
// Shared types and constants for the PS/2 mouse device emulator.
// Depends on nothing; every other file in rtl/ imports this package.
package ps2md_pkg;

	// Reply bytes and codes
	localparam logic [7:0] ACK_BYTE        = 8'hFA;
	localparam logic [7:0] RESEND_BYTE     = 8'hFE;
	localparam logic [7:0] SELFTEST_BYTE   = 8'hAA;
	localparam logic [7:0] RESOLUTION_BYTE = 8'h02;
	localparam logic [7:0] DEFAULT_RATE    = 8'd100;

	// Host commands
	localparam logic [7:0] CMD_RESET        = 8'hFF;
	localparam logic [7:0] CMD_SET_DEFAULTS = 8'hF6;
	localparam logic [7:0] CMD_DISABLE      = 8'hF5;
	localparam logic [7:0] CMD_STREAM_MODE  = 8'hEA;
	localparam logic [7:0] CMD_ENABLE       = 8'hF4;
	localparam logic [7:0] CMD_SET_RATE     = 8'hF3;
	localparam logic [7:0] CMD_GET_ID       = 8'hF2;
	localparam logic [7:0] CMD_STATUS       = 8'hE9;

	// Device identities and the set-rate sequences that unlock them
	localparam logic [2:0]  ID_STANDARD = 3'd0;
	localparam logic [2:0]  ID_WHEEL    = 3'd3;
	localparam logic [2:0]  ID_FIVE     = 3'd4;
	localparam logic [31:0] MAGIC_WHEEL = 32'h00C8_6450;
	localparam logic [31:0] MAGIC_FIVE  = 32'h00C8_C850;

	// Item kinds
	localparam logic KIND_HOST   = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	// Most bytes a single item can cause
	localparam int MAX_REPLY = 4;

	typedef struct packed {
		logic       command;
		logic [7:0] host_byte;
		logic       parity_ok;
		logic [7:0] buttons;
		logic [7:0] move_x;
		logic [7:0] move_y;
		logic [7:0] wheel;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       flush_queue;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [2:0]  device_id;
		logic        reporting_on;
		logic        awaiting_rate;
		logic [7:0]  sample_rate;
		logic [31:0] rate_history;
	} mouse_state_t;

	typedef struct packed {
		logic [MAX_REPLY-1:0][7:0] bytes;
		logic [2:0]                count;
		logic                      flush;
	} reply_t;

endpackage

// File: rtl/ps2md_reply.sv
// Reply decoder for the PS/2 mouse emulator: works out the bytes an item causes
// and the mouse state left behind. Purely combinational; depends on ps2md_pkg.
module ps2md_reply (
	input  ps2md_pkg::item_t        item,
	input  ps2md_pkg::mouse_state_t cur,
	output ps2md_pkg::reply_t       reply,
	output ps2md_pkg::mouse_state_t nxt
);
	import ps2md_pkg::*;

	logic [7:0]  hdr;
	logic [7:0]  dy;
	logic [7:0]  dz;
	logic [2:0]  wlow;
	logic [6:0]  ylow;
	logic [31:0] hist_shift;

	// Movement packet for a USB report
	always_comb begin
		ylow = item.move_y[6:0];
		hdr  = {4'b0000, 1'b1, item.buttons[2:0]};
		hdr[4] = item.move_x[7];
		if (item.move_y[7]) begin
			dy = 8'h80 - {1'b0, ylow};
		end else if (ylow != 7'd0) begin
			hdr[5] = 1'b1;
			dy = 8'h00 - {1'b0, ylow};
		end else begin
			dy = 8'h00;
		end
		wlow = item.wheel[2:0];
		if (item.wheel[7]) begin
			dz = 8'h08 - {5'd0, wlow};
		end else if (wlow != 3'd0) begin
			dz = 8'h10 - {5'd0, wlow};
		end else begin
			dz = 8'h00;
		end
		if (cur.device_id == ID_FIVE) begin
			dz[4] = item.buttons[3];
			dz[5] = item.buttons[4];
		end
	end

	assign hist_shift = {cur.rate_history[23:0], item.host_byte};

	// Command and report decode, and state update
	always_comb begin
		nxt = cur;
		reply.bytes = '0;
		reply.bytes[0] = ACK_BYTE;
		reply.count = 3'd1;
		reply.flush = 1'b0;
		if (item.command == KIND_REPORT) begin
			reply.bytes[0] = hdr;
			reply.bytes[1] = item.move_x;
			reply.bytes[2] = dy;
			reply.bytes[3] = dz;
			if (!cur.reporting_on) begin
				reply.count = 3'd0;
			end else if (cur.device_id == ID_WHEEL || cur.device_id == ID_FIVE) begin
				reply.count = 3'd4;
			end else begin
				reply.count = 3'd3;
			end
		end else if (!item.parity_ok) begin
			reply.bytes[0] = RESEND_BYTE;
		end else if (cur.awaiting_rate) begin
			// Rate argument: record it and look for the unlock sequences.
			nxt.sample_rate = item.host_byte;
			nxt.awaiting_rate = 1'b0;
			nxt.rate_history = hist_shift;
			if (cur.device_id == ID_STANDARD && hist_shift == MAGIC_WHEEL) begin
				nxt.device_id = ID_WHEEL;
			end else if (cur.device_id == ID_WHEEL && hist_shift == MAGIC_FIVE) begin
				nxt.device_id = ID_FIVE;
			end
		end else begin
			if (item.host_byte != CMD_SET_RATE) begin
				nxt.rate_history = '0;
			end
			case (item.host_byte)
				CMD_RESET: begin
					nxt.device_id = ID_STANDARD;
					nxt.reporting_on = 1'b0;
					nxt.sample_rate = DEFAULT_RATE;
					reply.flush = 1'b1;
					reply.bytes[1] = SELFTEST_BYTE;
					reply.bytes[2] = {5'd0, ID_STANDARD};
					reply.count = 3'd3;
				end
				CMD_SET_DEFAULTS: begin
					nxt.device_id = ID_STANDARD;
					nxt.reporting_on = 1'b0;
					nxt.sample_rate = DEFAULT_RATE;
				end
				CMD_DISABLE, CMD_STREAM_MODE: begin
					nxt.reporting_on = 1'b0;
				end
				CMD_ENABLE: begin
					nxt.reporting_on = 1'b1;
				end
				CMD_SET_RATE: begin
					nxt.awaiting_rate = 1'b1;
				end
				CMD_GET_ID: begin
					reply.bytes[1] = {5'd0, cur.device_id};
					reply.count = 3'd2;
				end
				CMD_STATUS: begin
					reply.bytes[1] = 8'h00;
					reply.bytes[2] = RESOLUTION_BYTE;
					reply.bytes[3] = cur.sample_rate;
					reply.count = 3'd4;
				end
				default: begin
					// Unknown commands are simply acknowledged.
				end
			endcase
		end
	end

endmodule

// File: rtl/ps2md_top_placeholder_never_used.sv
// Intentionally minimal helper: output byte sequencer for the PS/2 mouse emulator.
// Holds one reply burst and hands it out a beat at a time; depends on ps2md_pkg.
module ps2md_burst (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  ps2md_pkg::reply_t    reply,
	output logic                 free,
	output logic                 result_valid,
	input  logic                 result_stall,
	output ps2md_pkg::result_t   result
);
	import ps2md_pkg::*;

	logic                      valid_s2;
	logic [1:0]                idx_s2;
	logic [MAX_REPLY-1:0][7:0] bytes_s2;
	logic [2:0]                count_s2;
	logic                      flush_s2;
	logic                      at_end;
	logic                      take;

	assign take   = valid_s2 & ~result_stall;
	assign at_end = ({1'b0, idx_s2} == (count_s2 - 3'd1));
	assign free   = ~valid_s2 | (take & at_end);

	// Control: burst occupancy and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2 <= '0;
		end else if (free) begin
			valid_s2 <= load;
			idx_s2 <= '0;
		end else if (take) begin
			idx_s2 <= idx_s2 + 2'd1;
		end
	end

	// Payload: the reply bytes of the current burst
	always_ff @(posedge clk) begin
		if (free && load) begin
			bytes_s2 <= reply.bytes;
			count_s2 <= reply.count;
			flush_s2 <= reply.flush;
		end
	end

	assign result_valid       = valid_s2;
	assign result.out_byte    = bytes_s2[idx_s2];
	assign result.flush_queue = flush_s2 & (idx_s2 == 2'd0);
	assign result.last        = at_end;

endmodule

// File: rtl/ps2_mouse_device_emulator.sv
// PS/2 mouse device emulator with wheel and five-button extensions. Each
// accepted beat is a host byte or a USB boot report; the block answers with
// zero to four PS/2 bytes, one result beat per cycle while result_stall is low,
// last marking the final byte of an item. An item is registered on acceptance
// and decoded in the following cycle; its reply is loaded into the burst
// register once that is free, and the first byte is offered from there. A new
// item is taken every cycle while replies are single bytes and the receiver
// does not stall; an item causing several bytes holds the burst register until
// its last byte is taken, and the next item with a reply waits meanwhile.
// Reports while reporting is off pass through without a result.
// Depends on ps2md_pkg, ps2md_reply and ps2md_burst.
module ps2_mouse_device_emulator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  ps2md_pkg::item_t   item,
	output logic               result_valid,
	input  logic               result_stall,
	output ps2md_pkg::result_t result
);
	import ps2md_pkg::*;

	logic         valid_s1;
	item_t        item_s1;
	mouse_state_t state_q;
	mouse_state_t state_nxt;
	reply_t       reply;
	logic         burst_free;
	logic         go_s1;
	logic         take_in;

	// The registered item leaves once its reply can be loaded or it has none.
	assign go_s1      = valid_s1 & ((reply.count == 3'd0) | burst_free);
	assign item_stall = valid_s1 & ~go_s1;
	assign take_in    = item_valid & ~item_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || go_s1) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= item;
		end
	end

	// Mouse state advances as each item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.device_id <= ID_STANDARD;
			state_q.reporting_on <= 1'b0;
			state_q.awaiting_rate <= 1'b0;
			state_q.sample_rate <= DEFAULT_RATE;
			state_q.rate_history <= '0;
		end else if (go_s1) begin
			state_q <= state_nxt;
		end
	end

	ps2md_reply u_reply (
		.item  (item_s1),
		.cur   (state_q),
		.reply (reply),
		.nxt   (state_nxt)
	);

	ps2md_burst u_burst (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (go_s1 & (reply.count != 3'd0)),
		.reply        (reply),
		.free         (burst_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// File: tb/sv/tb_ps2md_reply_pkg.sv
// Scoreboard for the PS/2 mouse device emulator testbench: predicts reply bytes.
// Depends on ps2md_pkg for the beat types, reply codes and host commands.
package tb_ps2md_reply_pkg;

	import ps2md_pkg::*;

	class mouse_reply_tracker;
		logic [2:0]  device_id;
		logic        reporting_on;
		logic        awaiting_rate;
		logic [7:0]  sample_rate;
		logic [31:0] rate_history;
		result_t     pending_bytes[$];
		int          errors;

		function new();
			device_id     = ID_STANDARD;
			reporting_on  = 1'b0;
			awaiting_rate = 1'b0;
			sample_rate   = DEFAULT_RATE;
			rate_history  = '0;
			errors        = 0;
		endfunction

		// Append one expected byte; last is fixed up once the item is complete.
		function void add_byte(logic [7:0] b, logic flush);
			result_t r;
			r.out_byte    = b;
			r.flush_queue = flush;
			r.last        = 1'b0;
			pending_bytes.push_back(r);
		endfunction

		// Update the mouse state for an accepted beat and queue the bytes it causes.
		// Returns how many bytes were queued.
		function int note_item(item_t beat);
			int         before_count;
			int         produced;
			logic [7:0] d;
			logic [7:0] head;
			logic [7:0] dy;
			logic [7:0] dz;
			result_t    tail;
			before_count = pending_bytes.size();
			d = beat.host_byte;
			if (beat.command == KIND_HOST) begin
				if (!beat.parity_ok) begin
					add_byte(RESEND_BYTE, 1'b0);
				end else if (awaiting_rate) begin
					// Rate argument: the history of arguments unlocks the extended IDs.
					sample_rate   = d;
					awaiting_rate = 1'b0;
					rate_history  = {rate_history[23:0], d};
					if (device_id == ID_STANDARD && rate_history == MAGIC_WHEEL)
						device_id = ID_WHEEL;
					else if (device_id == ID_WHEEL && rate_history == MAGIC_FIVE)
						device_id = ID_FIVE;
					add_byte(ACK_BYTE, 1'b0);
				end else begin
					if (d != CMD_SET_RATE)
						rate_history = '0;
					case (d)
						CMD_RESET: begin
							device_id    = ID_STANDARD;
							reporting_on = 1'b0;
							sample_rate  = DEFAULT_RATE;
							add_byte(ACK_BYTE, 1'b1);
							add_byte(SELFTEST_BYTE, 1'b0);
							add_byte({5'b0, device_id}, 1'b0);
						end
						CMD_SET_DEFAULTS: begin
							device_id    = ID_STANDARD;
							sample_rate  = DEFAULT_RATE;
							reporting_on = 1'b0;
							add_byte(ACK_BYTE, 1'b0);
						end
						CMD_DISABLE, CMD_STREAM_MODE: begin
							reporting_on = 1'b0;
							add_byte(ACK_BYTE, 1'b0);
						end
						CMD_ENABLE: begin
							reporting_on = 1'b1;
							add_byte(ACK_BYTE, 1'b0);
						end
						CMD_SET_RATE: begin
							awaiting_rate = 1'b1;
							add_byte(ACK_BYTE, 1'b0);
						end
						CMD_GET_ID: begin
							add_byte(ACK_BYTE, 1'b0);
							add_byte({5'b0, device_id}, 1'b0);
						end
						CMD_STATUS: begin
							add_byte(ACK_BYTE, 1'b0);
							add_byte(8'h00, 1'b0);
							add_byte(RESOLUTION_BYTE, 1'b0);
							add_byte(sample_rate, 1'b0);
						end
						default: begin
							add_byte(ACK_BYTE, 1'b0);
						end
					endcase
				end
			end else if (reporting_on) begin
				// Movement packet: header with signs, X as is, Y negated.
				head = {5'b0, beat.buttons[2:0]} + 8'h08;
				if (beat.move_x[7])
					head = head + 8'h10;
				dy = {1'b0, beat.move_y[6:0]};
				if (beat.move_y[7]) begin
					dy = 8'h80 - dy;
				end else if (dy != 8'h00) begin
					head = head + 8'h20;
					dy   = 8'h00 - dy;
				end
				add_byte(head, 1'b0);
				add_byte(beat.move_x, 1'b0);
				add_byte(dy, 1'b0);
				// Fourth byte for the wheel identities, with extra buttons on the five-button one.
				if (device_id == ID_WHEEL || device_id == ID_FIVE) begin
					dz = {5'b0, beat.wheel[2:0]};
					if (beat.wheel[7])
						dz = 8'h08 - dz;
					else if (dz != 8'h00)
						dz = 8'h10 - dz;
					if (device_id == ID_FIVE) begin
						if (beat.buttons[3])
							dz = dz + 8'h10;
						if (beat.buttons[4])
							dz = dz + 8'h20;
					end
					add_byte(dz, 1'b0);
				end
			end
			produced = pending_bytes.size() - before_count;
			if (produced > 0) begin
				tail = pending_bytes.pop_back();
				tail.last = 1'b1;
				pending_bytes.push_back(tail);
			end
			return produced;
		endfunction

		// Compare an accepted result beat with the oldest expected byte.
		function void check_byte(result_t got);
			result_t want;
			if (pending_bytes.size() == 0) begin
				$error("out_byte: expected none, actual %h", got.out_byte);
				errors++;
				return;
			end
			want = pending_bytes.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
				errors++;
			end
			if (got.flush_queue !== want.flush_queue) begin
				$error("flush_queue: expected %b, actual %b", want.flush_queue, got.flush_queue);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %b, actual %b", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

endpackage

// File: tb/sv/tb_ps2_mouse_device_emulator.sv
// Testbench top for the PS/2 mouse device emulator: directed and random beats.
// Depends on ps2md_pkg, tb_ps2md_reply_pkg and the ps2_mouse_device_emulator RTL.
module tb_ps2_mouse_device_emulator;

	timeunit 1ns;
	timeprecision 1ps;

	import ps2md_pkg::*;
	import tb_ps2md_reply_pkg::*;

	localparam int RANDOM_ITEMS = 380;
	localparam int CALM_ITEMS   = 60;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT  = 2000;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	mouse_reply_tracker board;
	int  counted_items;
	int  idle_cycles;
	int  stall_left;
	bit  calm;
	bit  quiet;

	ps2_mouse_device_emulator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// Clock and known input values from time zero.
	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		result_stall = 1'b0;
		stall_left   = 0;
		calm         = 1'b0;
		quiet        = 1'b0;
		idle_cycles  = 0;
		counted_items = 0;
		board        = new();
	end

	always #1 clk = ~clk;

	// Watch both handshakes at the rising edge and feed the scoreboard.
	always @(posedge clk) begin
		if (arst_n) begin
			idle_cycles = idle_cycles + 1;
			if (item_valid && !item_stall) begin
				void'(board.note_item(item));
				counted_items = counted_items + 1;
				idle_cycles = 0;
			end
			if (result_valid && !result_stall) begin
				board.check_byte(result);
				idle_cycles = 0;
			end
		end
	end

	// Receiver back-pressure in random bursts, switched off in calm stretches.
	always @(negedge clk) begin
		if (calm || quiet) begin
			stall_left = 0;
			result_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			result_stall <= 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 14);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Watchdog: too long without any beat moving ends the run.
	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("tb_ps2_mouse_device_emulator: done, errors");
		$finish;
	end

	// Present one beat at a falling edge, optionally after an idle gap, and hold it
	// until accepted. Returns at the falling edge after acceptance with valid still high.
	task automatic send_item(item_t beat);
		int gap;
		gap = 0;
		if (!calm && !quiet && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 15);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= beat;
		do
			@(posedge clk);
		while (item_stall);
		@(negedge clk);
	endtask

	// Host byte; the report fields are filled with noise as the block ignores them.
	task automatic send_host(logic [7:0] code, logic par);
		item_t beat;
		beat           = item_t'({$urandom, $urandom});
		beat.command   = KIND_HOST;
		beat.host_byte = code;
		beat.parity_ok = par;
		send_item(beat);
	endtask

	// Mouse report; the host fields are filled with noise.
	task automatic send_report(logic [7:0] b, logic [7:0] x, logic [7:0] y, logic [7:0] w);
		item_t beat;
		beat         = item_t'({$urandom, $urandom});
		beat.command = KIND_REPORT;
		beat.buttons = b;
		beat.move_x  = x;
		beat.move_y  = y;
		beat.wheel   = w;
		send_item(beat);
	endtask

	// Three set-rate commands with their arguments; spoil damages one step.
	task automatic send_rate_sequence(logic [7:0] r0, logic [7:0] r1, logic [7:0] r2, bit spoil);
		logic [7:0] rates[3];
		int         bad_step;
		rates[0] = r0;
		rates[1] = r1;
		rates[2] = r2;
		bad_step = spoil ? int'($urandom_range(0, 5)) : -1;
		for (int i = 0; i < 3; i++) begin
			send_host(CMD_SET_RATE, 1'b1);
			if (bad_step == 2 * i)
				send_host(rates[i], 1'b0);
			if (bad_step == 2 * i + 1)
				rates[i] = 8'($urandom);
			send_host(rates[i], 1'b1);
		end
	endtask

	// Motion byte biased towards the sign and magnitude extremes.
	function automatic logic [7:0] pick_motion();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'h7F;
			2: return 8'h80;
			3: return 8'hFF;
			4: return 8'h01;
			default: return 8'($urandom);
		endcase
	endfunction

	// Host byte: mostly a known command, otherwise anything.
	function automatic logic [7:0] pick_command();
		case ($urandom_range(0, 11))
			0: return CMD_RESET;
			1: return CMD_SET_DEFAULTS;
			2: return CMD_DISABLE;
			3: return CMD_STREAM_MODE;
			4: return CMD_ENABLE;
			5: return CMD_SET_RATE;
			6: return CMD_GET_ID;
			7: return CMD_STATUS;
			default: return 8'($urandom);
		endcase
	endfunction

	// Main sequence: reset, directed beats, random scenarios, then drain and verdict.
	initial begin
		int         pick;
		int         burst;
		item_t      noise;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: bad parity, reset reply, queries and reports while off.
		send_host(CMD_ENABLE, 1'b0);
		send_host(CMD_RESET, 1'b1);
		send_report(8'h07, 8'h01, 8'h01, 8'h01);
		send_host(CMD_GET_ID, 1'b1);
		send_host(CMD_STATUS, 1'b1);
		// Standard three-byte packets with sign extremes.
		send_host(CMD_ENABLE, 1'b1);
		send_report(8'h07, 8'h80, 8'h80, 8'h80);
		send_report(8'h00, 8'h7F, 8'h7F, 8'h00);
		// Wheel upgrade, then four-byte packets with negative and positive wheel.
		send_rate_sequence(8'hC8, 8'h64, 8'h50, 1'b0);
		send_report(8'h1F, 8'hFF, 8'h01, 8'hFF);
		send_report(8'h00, 8'h01, 8'hFF, 8'h01);
		// Five-button rates, ignored as the history still holds the wheel ones.
		send_rate_sequence(8'hC8, 8'hC8, 8'h50, 1'b0);
		send_report(8'h18, 8'h00, 8'h00, 8'h80);
		send_host(CMD_GET_ID, 1'b1);
		send_host(8'h00, 1'b1);
		send_host(CMD_STREAM_MODE, 1'b1);
		send_host(CMD_SET_DEFAULTS, 1'b1);

		// Random scenarios, mostly well-formed command sequences and report bursts.
		counted_items = 0;
		while (counted_items < RANDOM_ITEMS) begin
			if (counted_items >= RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			if ($urandom_range(0, 9) == 0)
				quiet = !quiet;
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				send_host(pick_command(), 1'b1);
				send_rate_sequence(8'hC8, 8'h64, 8'h50, $urandom_range(0, 3) == 0);
			end else if (pick < 25) begin
				send_rate_sequence(8'hC8, 8'hC8, 8'h50, $urandom_range(0, 3) == 0);
			end else if (pick < 32) begin
				send_host(CMD_ENABLE, 1'b1);
				send_host(CMD_GET_ID, 1'b1);
			end else if (pick < 65) begin
				if (!board.reporting_on && $urandom_range(0, 3) != 0)
					send_host(CMD_ENABLE, 1'b1);
				burst = $urandom_range(1, 8);
				repeat (burst)
					send_report(8'($urandom), pick_motion(), pick_motion(), pick_motion());
			end else if (pick < 75) begin
				send_host(CMD_SET_RATE, 1'b1);
				send_host(8'($urandom), 1'b1);
				send_host(CMD_STATUS, 1'b1);
			end else if (pick < 85) begin
				send_host(pick_command(), $urandom_range(0, 7) != 0);
			end else if (pick < 90) begin
				case ($urandom_range(0, 3))
					0: send_host(CMD_RESET, 1'b1);
					1: send_host(CMD_SET_DEFAULTS, 1'b1);
					2: send_host(CMD_DISABLE, 1'b1);
					default: send_host(CMD_STREAM_MODE, 1'b1);
				endcase
			end else begin
				noise = item_t'({$urandom, $urandom});
				send_item(noise);
			end
		end
		item_valid <= 1'b0;

		// Drain: wait for every expected byte, then watch for anything stray.
		while (board.pending_bytes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (board.errors == 0)
			$display("tb_ps2_mouse_device_emulator: done, clean");
		else
			$display("tb_ps2_mouse_device_emulator: done, errors");
		$finish;
	end

endmodule

// File: files.f
rtl/ps2md_pkg.sv
rtl/ps2md_reply.sv
rtl/ps2md_top_placeholder_never_used.sv
rtl/ps2_mouse_device_emulator.sv
tb/sv/tb_ps2md_reply_pkg.sv
tb/sv/tb_ps2_mouse_device_emulator.sv
